@@ hdl/assert_macros.svh @@
// assertion macros shared by the checking code of the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/ptd_pkg.sv @@
// shared types and constants of the trial division primality tester
package ptd_pkg;

	// default width of the tested value
	localparam int DEFAULT_VALUE_WIDTH = 16;

	// first divisor tried, also the smallest prime
	localparam int SMALLEST_PRIME = 2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} ptd_state_t;

	// control from sequencer to remainder unit
	typedef struct packed {
		logic start;
	} ptd_rem_ctrl_t;

	// status from remainder unit to sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} ptd_rem_stat_t;

endpackage

@@ hdl/ptd_cand_if.sv @@
// candidate channel: valid/ready handshake carrying the number to test
interface ptd_cand_if #(
	parameter int VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

@@ hdl/ptd_res_if.sv @@
// result channel: valid/ready handshake carrying the echoed value and the verdict
interface ptd_res_if #(
	parameter int VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] tested_value;
	logic                   is_prime;

	modport source (output valid, output tested_value, output is_prime, input ready);
	modport sink (input valid, input tested_value, input is_prime, output ready);
endinterface

@@ hdl/prime_trial_division_test_top.sv @@
// 0 and 1 go from idle straight to finish, 2 and 3 finish at their first check; other
// candidates alternate check and divide for each divisor tried (2 up to floor(sqrt(n))),
// stopping at the first factor; one candidate at a time, paced by the one-bit-per-cycle
// remainder unit shared by all trial divisors
// reset: arst_n clears the sequencer, the remainder unit flags and the output valid
// a finished result waits in the output register while the next candidate is accepted
module prime_trial_division_test_top
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	ptd_cand_if.sink  cand_ch,
	ptd_res_if.source res_ch
);

	`include "assert_macros.svh"

	localparam int SW = VALUE_WIDTH + 2;
	localparam int FIRST_SQUARE = SMALLEST_PRIME * SMALLEST_PRIME;

	ptd_state_t             state_q;
	ptd_state_t             state_d;
	ptd_rem_ctrl_t          rem_ctrl;
	ptd_rem_stat_t          rem_stat;
	logic [VALUE_WIDTH-1:0] remainder;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [SW-1:0]          sq_q;
	logic                   prime_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_prime_q;
	logic                   cand_fire;
	logic                   cand_small;
	logic                   square_over;
	logic                   rem_zero;
	logic                   out_load;

	// shared remainder unit
	ptd_rem_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rem_ctrl),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (rem_stat),
		.remainder(remainder)
	);

	// decision terms
	assign cand_fire   = cand_ch.valid && cand_ch.ready;
	assign cand_small  = cand_ch.candidate < VALUE_WIDTH'(SMALLEST_PRIME);
	assign square_over = sq_q > {2'b00, n_q};
	assign rem_zero    = remainder == '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cand_fire) state_d = cand_small ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = square_over ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (rem_stat.done) state_d = rem_zero ? ST_FINISH : ST_CHECK;
			end
			ST_FINISH: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cand_ch.ready  = 1'b0;
		rem_ctrl.start = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE:   cand_ch.ready = 1'b1;
			ST_CHECK:  rem_ctrl.start = !square_over;
			ST_DIV:    ;
			ST_FINISH: out_load = !out_valid_q || res_ch.ready;
			default:   ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// candidate, trial divisor, its square and the verdict
	always_ff @(posedge clk) begin
		if (cand_fire) begin
			n_q     <= cand_ch.candidate;
			d_q     <= VALUE_WIDTH'(SMALLEST_PRIME);
			sq_q    <= SW'(FIRST_SQUARE);
			prime_q <= 1'b0;
		end else if (state_q == ST_CHECK && square_over) begin
			prime_q <= 1'b1;
		end else if (state_q == ST_DIV && rem_stat.done) begin
			if (rem_zero) begin
				prime_q <= 1'b0;
			end else begin
				// (d+1)^2 = d^2 + 2d + 1
				d_q  <= d_q + 1'b1;
				sq_q <= sq_q + {1'b0, d_q, 1'b1};
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= n_q;
			out_prime_q <= prime_q;
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.tested_value = out_value_q;
	assign res_ch.is_prime     = out_prime_q;

	// checks
	`AST_IMPLY(a_ready_unit_idle, clk, arst_n, cand_ch.ready, !rem_stat.busy && !rem_stat.done)
	`AST_IMPLY(a_done_in_div, clk, arst_n, rem_stat.done, state_q == ST_DIV)
	`AST_NEXT(a_small_finishes, clk, arst_n, cand_fire && cand_small, state_q == ST_FINISH)
	`AST_IMPLY(a_prime_at_least_two, clk, arst_n, res_ch.valid && res_ch.is_prime,
		res_ch.tested_value >= VALUE_WIDTH'(SMALLEST_PRIME))

endmodule

@@ hdl/ptd_rem_unit.sv @@
// shared remainder unit: restoring division, one quotient bit per cycle
module ptd_rem_unit
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptd_rem_ctrl_t          ctrl,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output ptd_rem_stat_t          stat,
	output logic [VALUE_WIDTH-1:0] remainder
);

	localparam int CW = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic [VALUE_WIDTH-1:0] rem_next;

	// shift in next dividend bit and subtract divisor when it fits
	always_comb begin
		trial    = {rem_q, dvd_q[VALUE_WIDTH-1]};
		diff     = trial - {1'b0, dvs_q};
		rem_next = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
	end

	// step counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

@@ tb/tb_top.sv @@
// self-checking bench for the trial division primality tester
module tb_top
	import ptd_pkg::*;
;

	localparam int VW          = DEFAULT_VALUE_WIDTH;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 116;
	localparam int HOLDOFF_CYCLES = 12000;
	localparam int HOLDOFF_AFTER  = 40;
	localparam int DRAIN_CYCLES   = 40;

	logic clk;
	logic arst_n;

	ptd_cand_if #(.VALUE_WIDTH(VW)) cand_ch ();
	ptd_res_if  #(.VALUE_WIDTH(VW)) res_ch ();

	prime_trial_division_test_top #(.VALUE_WIDTH(VW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand_ch(cand_ch),
		.res_ch (res_ch)
	);

	// trial division over 2 .. floor(sqrt(n)); zero and one are not prime
	function automatic bit primality_of(input logic [VW-1:0] n);
		int unsigned m;
		int unsigned d;
		m = n;
		if (m < SMALLEST_PRIME)
			return 1'b0;
		for (d = SMALLEST_PRIME; d * d <= m; d++) begin
			if (m % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	typedef struct {
		logic [VW-1:0] value;
		bit            prime;
	} verdict_t;

	// expected verdicts in candidate order, checked against each result beat
	class verdict_ledger;
		verdict_t pending[$];
		int       n_checked;
		int       n_prime;
		int       n_fail;

		task flag_mismatch(input string msg);
			n_fail++;
			$display("mismatch: %s", msg);
		endtask

		function void note_candidate(input logic [VW-1:0] v);
			verdict_t e;
			e.value = v;
			e.prime = primality_of(v);
			pending.push_back(e);
		endfunction

		task check_verdict(input logic [VW-1:0] tv, input logic ip);
			verdict_t e;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf("result value %0d prime %b with no candidate outstanding",
					tv, ip));
				return;
			end
			e = pending.pop_front();
			if (tv !== e.value)
				flag_mismatch($sformatf("tested_value %0d, expected %0d", tv, e.value));
			if (ip !== e.prime)
				flag_mismatch($sformatf("is_prime %b for %0d, expected %b", ip, e.value, e.prime));
			n_checked++;
			if (e.prime)
				n_prime++;
		endtask
	endclass

	verdict_ledger ledger = new();

	int unsigned cycle_count;
	int          stall_run;
	int          longest_stall;
	bit          holdoff_done;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// candidate beats feed the predictor; track input stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (cand_ch.valid && cand_ch.ready)
				ledger.note_candidate(cand_ch.candidate);
			if (cand_ch.valid && !cand_ch.ready) begin
				stall_run++;
				if (stall_run > longest_stall)
					longest_stall = stall_run;
			end else begin
				stall_run = 0;
			end
		end
	end

	// result beats are checked in order
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			ledger.check_verdict(res_ch.tested_value, res_ch.is_prime);
	end

	// receiver: randomly switching stall modes (always ready, repeating pattern, random), plus one long hold-off
	initial begin
		int          mode;
		int          phase;
		logic [15:0] stall_pat;
		mode      = 0;
		phase     = 0;
		stall_pat = '1;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!holdoff_done && ledger.n_checked >= HOLDOFF_AFTER) begin
				holdoff_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			if (phase % 64 == 0) begin
				mode      = $urandom_range(0, 2);
				stall_pat = 16'($urandom);
			end
			case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= stall_pat[phase % 16];
				default: res_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
			phase++;
			@(posedge clk);
		end
	end

	// offer one candidate and hold it until accepted
	task automatic offer_candidate(input logic [VW-1:0] v);
		cand_ch.valid     <= 1'b1;
		cand_ch.candidate <= v;
		do
			@(posedge clk);
		while (!cand_ch.ready);
	endtask

	// send a list of candidates in bursts with random gaps
	task automatic feed_candidates(input logic [VW-1:0] values[$]);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 12);
		foreach (values[i]) begin
			offer_candidate(values[i]);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 12);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
				cand_ch.valid     <= 1'b0;
				cand_ch.candidate <= VW'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		cand_ch.valid <= 1'b0;
	endtask

	// random candidate: small values most often, some full range, some hard composites and primes
	function automatic logic [VW-1:0] pick_candidate();
		int unsigned sel;
		int unsigned a;
		int unsigned b;
		int unsigned n;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			n = $urandom_range(0, 1023);
		end else if (sel < 70) begin
			n = $urandom_range(0, 65535);
		end else if (sel < 85) begin
			// product whose smallest factor may be large
			a = $urandom_range(2, 255);
			b = $urandom_range(a, 65535 / a);
			n = a * b;
		end else if (sel < 92) begin
			// walk down to the nearest prime, slowest case for the block
			n = $urandom_range(2, 65535);
			while (!primality_of(n[VW-1:0]))
				n--;
		end else begin
			// perfect square, factor sits exactly at the search bound
			a = $urandom_range(2, 255);
			n = a * a;
		end
		return n[VW-1:0];
	endfunction

	// main sequence
	initial begin
		logic [VW-1:0] directed_q[$];
		logic [VW-1:0] random_q[$];
		arst_n            <= 1'b0;
		cand_ch.valid     <= 1'b0;
		cand_ch.candidate <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero and one, two and three, squares at the bound, field extremes
		directed_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49,
			16'd97, 16'd255, 16'd256, 16'd257, 16'd32749, 16'd32767, 16'd32768,
			16'd63001, 16'd64009, 16'd65025, 16'd65521, 16'd65534, 16'd65535,
			16'hAAAA, 16'h5555};
		feed_candidates(directed_q);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			random_q.push_back(pick_candidate());
		@(posedge clk);
		feed_candidates(random_q);

		// drain
		while (ledger.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d candidates (%0d prime), directed edge values and random mix",
			ledger.n_checked, ledger.n_prime);
		$display("longest candidate stall %0d cycles during a %0d cycle result hold-off",
			longest_stall, HOLDOFF_CYCLES);
		if (ledger.n_fail == 0 && ledger.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ptd_pkg.sv
hdl/ptd_cand_if.sv
hdl/ptd_res_if.sv
hdl/ptd_rem_unit.sv
hdl/prime_trial_division_test_top.sv
tb/tb_top.sv
